FILE: hdl/smaf_pkg.sv
`timescale 1ns / 1ps

package smaf_pkg;

   // Per-cycle commands broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic clear;   // zero the stored magnitude (end of a stream)
      logic shift;   // take the neighbor's magnitude, the chain moves by one
      logic load;    // copy the stored magnitude into the probe, restart the rank
      logic step;    // count the probe in view, pass the probe on around the ring
   } ctrl_type;

endpackage

FILE: hdl/smaf_cell.sv
`timescale 1ns / 1ps

module smaf_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int INDEX_BITS  = 4,
   parameter int MY_IDX      = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smaf_pkg::ctrl_type     ctrl,
   input  logic                   in_window,
   input  logic [SAMPLE_BITS-1:0] prev_value,
   input  logic [SAMPLE_BITS-1:0] prev_pval,
   input  logic [INDEX_BITS-1:0]  prev_pidx,
   input  logic                   prev_pwin,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [SAMPLE_BITS-1:0] pval,
   output logic [INDEX_BITS-1:0]  pidx,
   output logic                   pwin,
   output logic [INDEX_BITS-1:0]  rank
);

   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [SAMPLE_BITS-1:0] pval_ff, pval_in;
   logic [INDEX_BITS-1:0]  pidx_ff, pidx_in;
   logic                   pwin_ff, pwin_in;
   logic [INDEX_BITS-1:0]  rank_ff, rank_in;
   logic                   hit;

   // The probe ranks below this cell if it is smaller, or equal and from a newer slot.
   assign hit = pwin_ff && ((pval_ff < value_ff) ||
                ((pval_ff == value_ff) && (pidx_ff < INDEX_BITS'(MY_IDX))));

   always_comb begin
      value_in = value_ff;
      pval_in  = pval_ff;
      pidx_in  = pidx_ff;
      pwin_in  = pwin_ff;
      rank_in  = rank_ff;
      if (ctrl.clear) begin
         value_in = '0;
      end else if (ctrl.shift) begin
         value_in = prev_value;
      end
      if (ctrl.load) begin
         pval_in = value_ff;
         pidx_in = INDEX_BITS'(MY_IDX);
         pwin_in = in_window;
         rank_in = '0;
      end else if (ctrl.step) begin
         rank_in = rank_ff + INDEX_BITS'(hit);
         pval_in = prev_pval;
         pidx_in = prev_pidx;
         pwin_in = prev_pwin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
      pval_ff <= pval_in;
      pidx_ff <= pidx_in;
      pwin_ff <= pwin_in;
      rank_ff <= rank_in;
   end

   assign value = value_ff;
   assign pval  = pval_ff;
   assign pidx  = pidx_ff;
   assign pwin  = pwin_ff;
   assign rank  = rank_ff;

endmodule

FILE: hdl/sliding_median_abs_filter.sv
`timescale 1ns / 1ps

// Running median over sample magnitudes.
// The req channel carries signed samples (tdata) with tlast on the final sample
// of a stream; the rsp channel returns one median magnitude per input sample, with
// tlast on the final median of the stream. The window size is to be written by the
// user through csr_we/csr_wdata only while the block is idle; the block does not
// enforce this; the window size resets to 5. A sample that owes no result leaves
// the block ready for the next sample. A sample that produces a median passes the
// transfer, a load step, rank steps in which a probe travels once around the ring
// of cells so that every cell counts its rank, and an output step that writes
// the median into the output register, where it shows as the block becomes ready
// for the next sample. A sample with tlast first pads the window with up to
// (w-1)/2 zeros, w being the effective window size, and then produces every owed
// median, each through its own load, rank and output steps, so rank counting
// around the ring sets the throughput.
// The output register lets a new sample be taken while a median still waits.
// Reset empties the window, clears the owed count and sets the window size to 5.
// When the receiver stalls, the finished median holds in the output register and
// the sequencer waits before writing the next one; input is taken again only
// once the owed medians of the current sample have been written out.
module sliding_median_abs_filter #(
   parameter int MAX_WINDOW  = 15,
   parameter int SAMPLE_BITS = 16,
   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,      // window_size
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,      // [SAMPLE_BITS-1:0] sample
   input  logic                 req_tlast,      // last_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,      // [SAMPLE_BITS-1:0] median
   output logic                 rsp_tlast       // last_out
);

   localparam int INDEX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RANK = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [3:0]             wsize_ff, wsize_in;
   logic [3:0]             pending_ff, pending_in;
   logic [3:0]             pad_ff, pad_in;
   logic                   last_ff, last_in;
   logic [INDEX_BITS-1:0]  cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [3:0]             w_eff;
   logic [3:0]             lag;
   logic [INDEX_BITS-1:0]  mid_idx;
   logic [SAMPLE_BITS-1:0] sample;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SAMPLE_BITS-1:0] push_val;
   logic [SAMPLE_BITS-1:0] median;
   logic                   out_free;
   logic                   req_xfer;
   smaf_pkg::ctrl_type     ctrl;

   logic [SAMPLE_BITS-1:0] value [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] pval  [MAX_WINDOW];
   logic [INDEX_BITS-1:0]  pidx  [MAX_WINDOW];
   logic                   pwin  [MAX_WINDOW];
   logic [INDEX_BITS-1:0]  rank  [MAX_WINDOW];
   logic                   in_win [MAX_WINDOW];

   // Effective window: zero counts as one, and the window never exceeds the chain.
   always_comb begin
      if (wsize_ff == 4'd0) begin
         w_eff = 4'd1;
      end else if (32'(wsize_ff) > MAX_WINDOW) begin
         w_eff = 4'(MAX_WINDOW);
      end else begin
         w_eff = wsize_ff;
      end
   end

   // The output lags its input by lag samples; the median is the rank w/2 entry.
   assign lag     = (w_eff - 4'd1) >> 1;
   assign mid_idx = INDEX_BITS'(w_eff >> 1);

   assign sample = req_tdata[SAMPLE_BITS-1:0];
   assign mag    = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         in_win[i] = (i < int'(w_eff));
      end
   end

   // Cell 0 is the newest slot; each cell takes its newer neighbor's value on a shift.
   // The probes form a ring so that every probe passes every cell once.
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      localparam int PREV = (g == 0) ? MAX_WINDOW - 1 : g - 1;
      logic [SAMPLE_BITS-1:0] prev_value;

      if (g == 0) begin : g_head
         assign prev_value = push_val;
      end else begin : g_body
         assign prev_value = value[PREV];
      end

      smaf_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .INDEX_BITS (INDEX_BITS),
         .MY_IDX     (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .in_window (in_win[g]),
         .prev_value(prev_value),
         .prev_pval (pval[PREV]),
         .prev_pidx (pidx[PREV]),
         .prev_pwin (pwin[PREV]),
         .value     (value[g]),
         .pval      (pval[g]),
         .pidx      (pidx[g]),
         .pwin      (pwin[g]),
         .rank      (rank[g])
      );
   end

   // Ranks inside the window are distinct, so exactly one cell matches.
   always_comb begin
      median = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (in_win[i] && (rank[i] == mid_idx)) begin
            median = median | value[i];
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      wsize_in     = csr_we ? csr_wdata : wsize_ff;
      pending_in   = pending_ff;
      pad_in       = pad_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      push_val     = '0;
      ctrl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               push_val   = mag;
               ctrl.shift = 1'b1;
               pending_in = pending_ff + 4'd1;
               last_in    = req_tlast;
               pad_in     = '0;
               if (req_tlast) begin
                  state_in = ST_PAD;
               end else if ((pending_ff + 4'd1) > lag) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PAD: begin
            // Feed zeros until the newest owed sample sits at the output position.
            if (({1'b0, pending_ff} + {1'b0, pad_ff}) <= {1'b0, lag}) begin
               ctrl.shift = 1'b1;
               pad_in     = pad_ff + 4'd1;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.load = 1'b1;
            cnt_in    = '0;
            state_in  = ST_RANK;
         end
         ST_RANK: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == INDEX_BITS'(MAX_WINDOW - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = median;
               rsp_last_in  = last_ff && (pending_ff == 4'd1);
               if (!last_ff) begin
                  pending_in = lag;
                  state_in   = ST_IDLE;
               end else if (pending_ff == 4'd1) begin
                  // Final median of the stream: the next stream starts from zeros.
                  ctrl.clear = 1'b1;
                  pending_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  ctrl.shift = 1'b1;
                  pending_in = pending_ff - 4'd1;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wsize_ff     <= 4'd5;
         pending_ff   <= '0;
         pad_ff       <= '0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wsize_ff     <= wsize_in;
         pending_ff   <= pending_in;
         pad_ff       <= pad_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/smaf_checker.sv
`timescale 1ns / 1ps

module smaf_checker #(
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_BITS   = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 req_tlast,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [DATA_BITS-1:0] rsp_tdata,
   input logic                 rsp_tlast
);

   // A stalled result transfer keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // A median magnitude never exceeds the magnitude of the most negative sample.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[SAMPLE_BITS-1] && (|rsp_tdata[SAMPLE_BITS-2:0])))
      else $error("rsp median out of range");

   // The end of a stream always starts a flush, so no sample is taken right after it.
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken during flush");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind sliding_median_abs_filter smaf_checker #(
   .SAMPLE_BITS(SAMPLE_BITS),
   .DATA_BITS  (DATA_BITS)
) u_smaf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast (req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
